### design/lprl_pkg.sv
// ----------------------------------------------------------------------------
// lprl_pkg
// Shared types and constants for the longest-prefix route lookup block.
// ----------------------------------------------------------------------------
package lprl_pkg;

  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 8;
  localparam int SLOT_W   = 10;   // width of the slot fields on the ports
  localparam int ACTIVE_W = 11;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } route_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic issue;      // read the next table slot
    logic load_out;   // move the finished result into the output register
  } lprl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // every active slot has been issued
    logic busy;       // compare pipeline still holds a slot
  } lprl_stat_t;

endpackage

### design/lprl_ctrl.sv
// ----------------------------------------------------------------------------
// lprl_ctrl
// Sequencer: takes one transaction, walks the table scan for a lookup, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
module lprl_ctrl
  import lprl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_cmd,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output lprl_cmd_t  cmd,
  input  lprl_stat_t stat
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_cmd == CMD_LOOKUP) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      ST_FINISH: begin
        // wait for the compare pipeline to empty and the output slot to free up
        if (!stat.busy && out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/lprl_dp.sv
// ----------------------------------------------------------------------------
// lprl_dp
// Route table memory, slot counter, three-stage compare pipeline, best-match
// registers and the output register.
// ----------------------------------------------------------------------------
module lprl_dp
  import lprl_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lprl_cmd_t           cmd,
  output lprl_stat_t          stat,
  input  logic                cfg_we,
  input  logic [ACTIVE_W-1:0] cfg_active_entries,
  input  logic                in_cmd,
  input  logic [SLOT_W-1:0]   in_entry_index,
  input  logic [ADDR_W-1:0]   in_entry_prefix,
  input  logic [ADDR_W-1:0]   in_entry_mask,
  input  logic [ADDR_W-1:0]   in_entry_gateway,
  input  logic [PORT_W-1:0]   in_entry_port,
  input  logic [ADDR_W-1:0]   in_lookup_addr,
  output logic                out_found,
  output logic [ADDR_W-1:0]   out_gateway,
  output logic [PORT_W-1:0]   out_out_port,
  output logic [SLOT_W-1:0]   out_match_index
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int LIM_W = IDX_W + 1;

  route_entry_t mem [TABLE_DEPTH];

  logic [ACTIVE_W-1:0] active_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [LIM_W-1:0]    lim_r, lim_nxt;
  logic [LIM_W-1:0]    cnt_r;

  // stage 1: registered memory read
  route_entry_t        rd_data_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic                rd_vld_r;

  // stage 2: match result
  logic                m_hit_r;
  logic [ADDR_W-1:0]   m_mask_r;
  logic [ADDR_W-1:0]   m_hop_r;
  logic [PORT_W-1:0]   m_port_r;
  logic [IDX_W-1:0]    m_idx_r;

  // stage 3: best so far
  logic                hit_r;
  logic [ADDR_W-1:0]   best_mask_r;
  logic [ADDR_W-1:0]   best_hop_r;
  logic [PORT_W-1:0]   best_port_r;
  logic [IDX_W-1:0]    best_idx_r;

  logic                out_found_r;
  logic [ADDR_W-1:0]   out_hop_r;
  logic [PORT_W-1:0]   out_port_r;
  logic [SLOT_W-1:0]   out_idx_r;

  logic                wr_en;
  logic                upd;
  route_entry_t        wr_data;

  assign wr_en = cmd.accept && (in_cmd == CMD_WRITE)
                 && (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign wr_data = '{prefix: in_entry_prefix, mask: in_entry_mask,
                     hop: in_entry_gateway, port: in_entry_port};

  // active count clipped to the table size
  always_comb begin
    if (32'(active_r) > 32'(TABLE_DEPTH)) begin
      lim_nxt = LIM_W'(TABLE_DEPTH);
    end else begin
      lim_nxt = LIM_W'(active_r);
    end
  end

  // equal masks keep the earlier slot, so only a strictly longer mask replaces
  assign upd = m_hit_r && (!hit_r || (m_mask_r > best_mask_r));

  assign stat.scan_done = (cnt_r >= lim_r);
  assign stat.busy      = rd_vld_r || m_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(in_entry_index)] <= wr_data;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[cnt_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      m_hit_r  <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_r <= cfg_active_entries;
      end
      if (cmd.accept) begin
        cnt_r <= '0;
      end else if (cmd.issue) begin
        cnt_r <= cnt_r + LIM_W'(1);
      end
      rd_vld_r <= cmd.issue;
      m_hit_r  <= rd_vld_r && (rd_data_r.prefix == (addr_r & rd_data_r.mask));
      if (cmd.accept) begin
        hit_r <= 1'b0;
      end else if (upd) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r <= in_lookup_addr;
      lim_r  <= lim_nxt;
    end
    if (cmd.issue) begin
      rd_idx_r <= cnt_r[IDX_W-1:0];
    end
    m_mask_r <= rd_data_r.mask;
    m_hop_r  <= rd_data_r.hop;
    m_port_r <= rd_data_r.port;
    m_idx_r  <= rd_idx_r;
    if (upd) begin
      best_mask_r <= m_mask_r;
      best_hop_r  <= m_hop_r;
      best_port_r <= m_port_r;
      best_idx_r  <= m_idx_r;
    end
    if (cmd.load_out) begin
      out_found_r <= hit_r;
      out_hop_r   <= hit_r ? best_hop_r : '0;
      out_port_r  <= hit_r ? best_port_r : '0;
      out_idx_r   <= hit_r ? SLOT_W'(best_idx_r) : '0;
    end
  end

  assign out_found       = out_found_r;
  assign out_gateway     = out_hop_r;
  assign out_out_port    = out_port_r;
  assign out_match_index = out_idx_r;

endmodule

### design/longest_prefix_route_lookup_core.sv
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_core
// IPv4 longest-prefix route table with write and lookup transactions.
// ----------------------------------------------------------------------------
// Each input transaction either writes one route slot or looks up a
// destination address; each gives exactly one result. A lookup walks slots
// 0 .. min(active_entries, TABLE_DEPTH)-1 through the table's single read
// port at one slot per cycle. The input stays stalled from acceptance until
// the scan has finished, the compare pipeline has emptied and the result
// has been loaded into the output register; a write skips the scan. A
// finished result sits in the output register, so the next transaction is
// accepted while it waits; only a result still held there by out_stall
// delays the following one. Ties on mask value go to the lowest slot.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup_core
  import lprl_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ACTIVE_W-1:0] cfg_active_entries,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  logic [SLOT_W-1:0]   in_entry_index,
  input  logic [ADDR_W-1:0]   in_entry_prefix,
  input  logic [ADDR_W-1:0]   in_entry_mask,
  input  logic [ADDR_W-1:0]   in_entry_gateway,
  input  logic [PORT_W-1:0]   in_entry_port,
  input  logic [ADDR_W-1:0]   in_lookup_addr,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_found,
  output logic [ADDR_W-1:0]   out_gateway,
  output logic [PORT_W-1:0]   out_out_port,
  output logic [SLOT_W-1:0]   out_match_index
);

  lprl_cmd_t  cmd;
  lprl_stat_t stat;

  assign cfg_ready = 1'b1;

  lprl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  lprl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_active_entries (cfg_active_entries),
    .in_cmd             (in_cmd),
    .in_entry_index     (in_entry_index),
    .in_entry_prefix    (in_entry_prefix),
    .in_entry_mask      (in_entry_mask),
    .in_entry_gateway   (in_entry_gateway),
    .in_entry_port      (in_entry_port),
    .in_lookup_addr     (in_lookup_addr),
    .out_found          (out_found),
    .out_gateway        (out_gateway),
    .out_out_port       (out_out_port),
    .out_match_index    (out_match_index)
  );

endmodule

### design/lprl_checker.sv
// ----------------------------------------------------------------------------
// lprl_checker
// Port-level checks for the route lookup core, bound to the top level.
// ----------------------------------------------------------------------------
module lprl_checker
  import lprl_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_found,
  input logic [ADDR_W-1:0] out_gateway,
  input logic [PORT_W-1:0] out_out_port,
  input logic [SLOT_W-1:0] out_match_index
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_found) && $stable(out_gateway)
      && $stable(out_out_port) && $stable(out_match_index))
    else $error("stalled result changed");

  // a miss reports all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_gateway == '0) && (out_out_port == '0)
      && (out_match_index == '0))
    else $error("miss with nonzero result fields");

  // one transaction at a time: the cycle after an accept the input is held off
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken before the first finished");

endmodule

bind longest_prefix_route_lookup_core lprl_checker u_lprl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_found       (out_found),
  .out_gateway     (out_gateway),
  .out_out_port    (out_out_port),
  .out_match_index (out_match_index)
);
